// ----- rtl/core/dnce_pkg.sv -----
// shared types and constants for the disc neighbor cell enumerator
// no dependencies
`timescale 1ns / 1ps

package dnce_pkg;

  localparam int unsigned QW        = 20;
  localparam int unsigned NW        = 10;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_CELLS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ  = 2'd3;

  localparam logic [CFG_W-1:0] RST_MAP_ROWS   = 11'd1024;
  localparam logic [CFG_W-1:0] RST_MAP_COLS   = 11'd1024;
  localparam logic [1:0]       RST_SPAN_CELLS = 2'd1;
  localparam logic [4:0]       RST_RADIUS_SQ  = 5'd2;

  typedef struct packed {
    logic [QW-1:0] query_index;
  } query_t;

  typedef struct packed {
    logic [QW-1:0] neighbor_index;
    logic [NW-1:0] neighbor_row;
    logic [NW-1:0] neighbor_col;
    logic          last;
  } result_t;

  // squared magnitude of a small offset
  function automatic logic [3:0] offset_sq(input logic [1:0] mag);
    logic [3:0] res;
    case (mag)
      2'd0:    res = 4'd0;
      2'd1:    res = 4'd1;
      2'd2:    res = 4'd4;
      default: res = 4'd9;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/core/dnce_if.sv -----
// valid/ready channel interfaces for queries and neighbor results
// depends on dnce_pkg
`timescale 1ns / 1ps

interface dnce_query_if import dnce_pkg::*; ();
  logic   valid;
  logic   ready;
  query_t payload;

  modport source  (output valid, output payload, input ready);
  modport sink    (input valid, input payload, output ready);
  modport monitor (input valid, input payload, input ready);
endinterface

interface dnce_result_if import dnce_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source  (output valid, output payload, input ready);
  modport sink    (input valid, input payload, output ready);
  modport monitor (input valid, input payload, input ready);
endinterface

// ----- rtl/core/disc_neighbor_cell_enumerator_unit.sv -----
// disc neighbor cell enumerator: splits a linear cell index and walks its disc neighborhood
// depends on dnce_pkg and dnce_if
//
//   channel    dir  handshake           payload
//   query_i    in   valid / ready       query_index
//   result_o   out  valid / ready       neighbor_index, neighbor_row, neighbor_col, last
//   cfg        in   cfg_we_i            cfg_idx_i, cfg_wdata_i
//
// a query runs the divide, pre-step, scan and flush states; a restoring divider and
// the index walk share one adder, one bit or one offset per cycle unless the scan stalls;
// query_i.ready is high only while idle; results leave through one output register
// a full output register holds the scan at the next kept neighbor until the result is taken
// reset returns to idle with configuration at its defaults
`timescale 1ns / 1ps

module disc_neighbor_cell_enumerator_unit import dnce_pkg::*; #(
  parameter int unsigned MAX_SPAN = 3,
  parameter int unsigned MAX_DIM  = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  dnce_query_if.sink           query_i,
  dnce_result_if.source        result_o
);

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned AW    = (DIM_W + 2 > QW + 1) ? DIM_W + 2 : QW + 1;
  localparam int unsigned RW    = QW + 2;
  localparam int unsigned CW    = DIM_W + 2;
  localparam logic [4:0]  DIV_LAST = 5'(QW - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_PRE   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [CFG_W-1:0] rows_cfg_q, cols_cfg_q;
  logic [1:0]       span_cfg_q;
  logic [4:0]       lim_q;

  logic [2:0]       state_q, state_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [QW-1:0]    dq_q, dq_d;
  logic [DIM_W-1:0] rem_q, rem_d;
  logic [QW-1:0]    lin_q, lin_d;
  logic [2:0]       dr_q, dr_d, dc_q, dc_d;
  logic             held_valid_q, held_valid_d;
  result_t          held_q, held_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_q, out_d;

  logic [DIM_W-1:0] rows_c, cols_c;
  logic [1:0]       span_c;
  logic [2:0]       span3;
  logic [AW-1:0]    alu_a, alu_b, alu_sum, row_step;
  logic [DIM_W:0]   shifted;
  logic             trial_neg;
  logic [1:0]       dr_mag, dc_mag;
  logic [4:0]       dist_sq;
  logic signed [RW-1:0] r_s;
  logic signed [CW-1:0] c_s;
  logic             r_ok, c_ok, keep, out_free, stall, accept, dims_ok;
  result_t          cur;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= RST_MAP_ROWS;
      cols_cfg_q <= RST_MAP_COLS;
      span_cfg_q <= RST_SPAN_CELLS;
      lim_q      <= RST_RADIUS_SQ;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAP_ROWS:   rows_cfg_q <= cfg_wdata_i;
        CFG_MAP_COLS:   cols_cfg_q <= cfg_wdata_i;
        CFG_SPAN_CELLS: span_cfg_q <= cfg_wdata_i[1:0];
        CFG_RADIUS_SQ:  lim_q      <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  assign rows_c  = (32'(rows_cfg_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(rows_cfg_q);
  assign cols_c  = (32'(cols_cfg_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cols_cfg_q);
  assign span_c  = (32'(span_cfg_q) > MAX_SPAN) ? 2'(MAX_SPAN) : span_cfg_q;
  assign span3   = {1'b0, span_c};
  assign dims_ok = (rows_c != '0) && (cols_c != '0);

  assign row_step = AW'(cols_c) - AW'({span_c, 1'b0});
  assign shifted  = {rem_q, dq_q[QW-1]};

  // shared adder
  always_comb begin
    alu_a = AW'(lin_q);
    alu_b = '0;
    unique case (state_q)
      S_DIV: begin
        alu_a = AW'(shifted);
        alu_b = -AW'(cols_c);
      end
      S_PRE:  alu_b = (cnt_q != '0) ? -AW'(cols_c) : -AW'(span_c);
      S_SCAN: alu_b = (dc_q == span3) ? row_step : AW'(1);
      default: ;
    endcase
  end

  assign alu_sum   = alu_a + alu_b;
  assign trial_neg = alu_sum[AW-1];

  // offset test for the current scan position
  assign dr_mag  = dr_q[2] ? 2'(-dr_q) : dr_q[1:0];
  assign dc_mag  = dc_q[2] ? 2'(-dc_q) : dc_q[1:0];
  assign dist_sq = 5'(offset_sq(dr_mag)) + 5'(offset_sq(dc_mag));

  assign r_s  = $signed({2'b00, dq_q}) + $signed({{(RW-3){dr_q[2]}}, dr_q});
  assign c_s  = $signed({2'b00, rem_q}) + $signed({{(CW-3){dc_q[2]}}, dc_q});
  assign r_ok = !r_s[RW-1] && (r_s[RW-2:0] < (RW-1)'(rows_c));
  assign c_ok = !c_s[CW-1] && (c_s[CW-2:0] < (CW-1)'(cols_c));
  assign keep = (dist_sq <= lim_q) && r_ok && c_ok;

  assign cur.neighbor_index = lin_q;
  assign cur.neighbor_row   = r_s[NW-1:0];
  assign cur.neighbor_col   = NW'(c_s);
  assign cur.last           = 1'b0;

  assign out_free = !out_valid_q || result_o.ready;
  assign stall    = keep && held_valid_q && !out_free;
  assign accept   = query_i.valid && query_i.ready;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    dq_d         = dq_q;
    rem_d        = rem_q;
    lin_d        = lin_q;
    dr_d         = dr_q;
    dc_d         = dc_q;
    held_valid_d = held_valid_q;
    held_d       = held_q;
    out_valid_d  = out_valid_q && !result_o.ready;
    out_d        = out_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          dq_d  = query_i.payload.query_index;
          lin_d = query_i.payload.query_index;
          rem_d = '0;
          cnt_d = DIV_LAST;
          if (dims_ok) state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = trial_neg ? shifted[DIM_W-1:0] : alu_sum[DIM_W-1:0];
        dq_d  = {dq_q[QW-2:0], ~trial_neg};
        if (cnt_q == '0) begin
          cnt_d   = 5'(span_c);
          state_d = S_PRE;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      S_PRE: begin
        lin_d = alu_sum[QW-1:0];
        if (cnt_q == '0) begin
          dr_d    = -span3;
          dc_d    = -span3;
          state_d = S_SCAN;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      S_SCAN: begin
        if (!stall) begin
          lin_d = alu_sum[QW-1:0];
          if (keep) begin
            if (held_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = held_q;
            end
            held_valid_d = 1'b1;
            held_d       = cur;
          end
          if (dc_q == span3) begin
            if (dr_q == span3) begin
              state_d = S_FLUSH;
            end else begin
              dr_d = dr_q + 3'd1;
              dc_d = -span3;
            end
          end else begin
            dc_d = dc_q + 3'd1;
          end
        end
      end
      S_FLUSH: begin
        if (!held_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_d        = held_q;
          out_d.last   = 1'b1;
          held_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      dr_q         <= '0;
      dc_q         <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      dr_q         <= dr_d;
      dc_q         <= dc_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    lin_q  <= lin_d;
    held_q <= held_d;
    out_q  <= out_d;
  end

  assign query_i.ready    = (state_q == S_IDLE);
  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

endmodule

// ----- rtl/core/dnce_checker.sv -----
// port-level checks for the disc neighbor cell enumerator, bound to the top level
// depends on dnce_pkg, dnce_if and disc_neighbor_cell_enumerator_unit
`timescale 1ns / 1ps

module dnce_checker import dnce_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 query_valid_i,
  input  logic                 query_ready_i,
  input  logic                 result_valid_i,
  input  logic                 result_ready_i,
  input  result_t              result_payload_i
);

  logic [CFG_W-1:0] rows_q, cols_q;
  logic             open_q;
  logic             in_acc, out_acc, dims_ok;

  assign in_acc  = query_valid_i && query_ready_i;
  assign out_acc = result_valid_i && result_ready_i;
  assign dims_ok = (rows_q != '0) && (cols_q != '0);

  // shadow of the map size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RST_MAP_ROWS;
      cols_q <= RST_MAP_COLS;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MAP_ROWS) rows_q <= cfg_wdata_i;
      if (cfg_idx_i == CFG_MAP_COLS) cols_q <= cfg_wdata_i;
    end
  end

  // a query on a nonzero map is open from its acceptance until its last result is taken while idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else if (in_acc && dims_ok) begin
      open_q <= 1'b1;
    end else if (out_acc && result_payload_i.last && query_ready_i) begin
      open_q <= 1'b0;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_i && !result_ready_i) |=> (result_valid_i && $stable(result_payload_i)))
    else $error("result dropped or changed while stalled");

  a_busy_after_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && dims_ok) |=> !query_ready_i)
    else $error("query accepted while a query is in progress");

  a_no_stray_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> !result_valid_i)
    else $error("result without an open query");

  a_idle_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (query_ready_i && result_valid_i) |-> result_payload_i.last)
    else $error("idle with a non-final result pending");

endmodule

bind disc_neighbor_cell_enumerator_unit dnce_checker u_dnce_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .cfg_we_i         (cfg_we_i),
  .cfg_idx_i        (cfg_idx_i),
  .cfg_wdata_i      (cfg_wdata_i),
  .query_valid_i    (query_i.valid),
  .query_ready_i    (query_i.ready),
  .result_valid_i   (result_o.valid),
  .result_ready_i   (result_o.ready),
  .result_payload_i (result_o.payload)
);

// ----- dv/disc_neighbor_cell_enumerator_unit_tb.sv -----
// testbench for disc_neighbor_cell_enumerator_unit: random and directed queries, checked
// against an in-bench expansion of each query's disc neighborhood
// depends on dnce_pkg, dnce_if and the unit itself
`timescale 1ns / 1ps

module disc_neighbor_cell_enumerator_unit_tb;
  import dnce_pkg::*;

  localparam int MAX_SPAN    = 3;
  localparam int MAX_DIM     = 1024;
  localparam int SETTLE_CYC  = 120;
  localparam int HOLD_CYC    = 400;
  localparam int STALL_LIMIT = 4000;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_MAP_ROWS;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  logic   q_valid = 1'b0;
  query_t q_payload = '0;
  logic   r_ready = 1'b0;

  dnce_query_if  query_if ();
  dnce_result_if result_if ();

  assign query_if.valid   = q_valid;
  assign query_if.payload = q_payload;
  assign result_if.ready  = r_ready;

  disc_neighbor_cell_enumerator_unit #(
    .MAX_SPAN (MAX_SPAN),
    .MAX_DIM  (MAX_DIM)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .query_i     (query_if),
    .result_o    (result_if)
  );

  always #6 clk = ~clk;

  // shadow of the configuration registers
  int cfg_rows  = int'(RST_MAP_ROWS);
  int cfg_cols  = int'(RST_MAP_COLS);
  int cfg_span  = int'(RST_SPAN_CELLS);
  int cfg_limit = int'(RST_RADIUS_SQ);

  query_t  query_backlog[$];
  result_t expected_neighbors[$];

  int q_issued     = 0;
  int q_accepted   = 0;
  int results_seen = 0;
  int err_cnt      = 0;

  function automatic int eff_dim(input int v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

  // expand one centre cell into its in-map disc neighbors, in scan order
  function automatic void expand_query(input logic [QW-1:0] q);
    int rows, cols, span, cr, cc, r, c;
    result_t held;
    bit have_held;
    rows = eff_dim(cfg_rows);
    cols = eff_dim(cfg_cols);
    span = (cfg_span > MAX_SPAN) ? MAX_SPAN : cfg_span;
    have_held = 1'b0;
    held = '0;
    if (rows == 0 || cols == 0) return;
    cc = int'(q) % cols;
    cr = int'(q) / cols;
    for (int dr = -span; dr <= span; dr++) begin
      for (int dc = -span; dc <= span; dc++) begin
        r = cr + dr;
        c = cc + dc;
        if (dr * dr + dc * dc > cfg_limit) continue;
        if (r < 0 || r >= rows || c < 0 || c >= cols) continue;
        if (have_held) expected_neighbors = {expected_neighbors, held};
        held.neighbor_index = QW'(r * cols + c);
        held.neighbor_row   = NW'(r);
        held.neighbor_col   = NW'(c);
        held.last           = 1'b0;
        have_held = 1'b1;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      expected_neighbors = {expected_neighbors, held};
    end
  endfunction

  // mostly centres inside the map, biased toward its edges
  function automatic query_t pick_query();
    int rows, cols, r, c;
    query_t q;
    rows = eff_dim(cfg_rows);
    cols = eff_dim(cfg_cols);
    if (rows == 0 || cols == 0 || $urandom_range(0, 6) == 0) begin
      q.query_index = QW'($urandom);
    end else begin
      case ($urandom_range(0, 5))
        0:       r = 0;
        1:       r = rows - 1;
        2:       r = (rows > 1) ? 1 : 0;
        default: r = $urandom_range(0, rows - 1);
      endcase
      case ($urandom_range(0, 5))
        0:       c = 0;
        1:       c = cols - 1;
        2:       c = (cols > 2) ? cols - 2 : 0;
        default: c = $urandom_range(0, cols - 1);
      endcase
      q.query_index = QW'(r * cols + c);
    end
    return q;
  endfunction

  function automatic int pick_dim();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 0;
    if (sel <= 2) return MAX_DIM;
    if (sel == 3) return $urandom_range(MAX_DIM + 1, 2047);
    if (sel <= 6) return $urandom_range(1, 3);
    return $urandom_range(4, 32);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MAP_ROWS:   cfg_rows = int'(val);
      CFG_MAP_COLS:   cfg_cols = int'(val);
      CFG_SPAN_CELLS: cfg_span = int'(val[1:0]);
      default:        cfg_limit = int'(val[4:0]);
    endcase
  endtask

  task automatic apply_config(input int rows_v, input int cols_v, input int span_v,
                              input int lim_v);
    write_reg(CFG_MAP_ROWS, CFG_W'(rows_v));
    write_reg(CFG_MAP_COLS, CFG_W'(cols_v));
    write_reg(CFG_SPAN_CELLS, CFG_W'(span_v));
    write_reg(CFG_RADIUS_SQ, CFG_W'(lim_v));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drain();
    while (query_backlog.size() != 0 || q_issued != q_accepted ||
           expected_neighbors.size() != 0)
      @(negedge clk);
  endtask

  // a query with no neighbors leaves no trace in the expected store
  task automatic settle();
    wait_drain();
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic push_query(input int v);
    query_t q;
    q.query_index = QW'(v);
    query_backlog = {query_backlog, q};
  endtask

  // query driver, bursts with random gaps
  int gap_left   = 0;
  int burst_left = 0;

  always @(negedge clk) begin
    if (q_issued == q_accepted) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        q_valid  <= 1'b0;
      end else if (rst_n && query_backlog.size() != 0) begin
        q_payload <= query_backlog.pop_front();
        q_valid   <= 1'b1;
        q_issued  <= q_issued + 1;
        if (burst_left <= 1) begin
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          burst_left <= $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        q_valid <= 1'b0;
      end
    end
  end

  // result ready pattern with one long hold-off
  rx_mode_e rx_mode   = RX_OPEN;
  int       mode_left = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  int       rx_tick   = 0;

  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      r_ready   <= 1'b0;
    end else if (!hold_done && results_seen > 200 && query_backlog.size() >= 8) begin
      hold_left <= HOLD_CYC;
      hold_done <= 1'b1;
      r_ready   <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(16, 128);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   r_ready <= 1'b1;
        RX_RANDOM: r_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: r_ready <= ($urandom_range(0, 3) == 0);
        default:   r_ready <= ((rx_tick % 5) != 0);
      endcase
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n) begin
      if (result_if.valid && result_if.ready) begin
        got = result_if.payload;
        results_seen++;
        if (expected_neighbors.size() == 0) begin
          $error("unexpected neighbor transaction: index %0d row %0d col %0d",
                 got.neighbor_index, got.neighbor_row, got.neighbor_col);
          err_cnt++;
        end else begin
          want = expected_neighbors.pop_front();
          if (got.neighbor_index !== want.neighbor_index) begin
            $error("neighbor_index: expected %0d, got %0d", want.neighbor_index,
                   got.neighbor_index);
            err_cnt++;
          end
          if (got.neighbor_row !== want.neighbor_row) begin
            $error("neighbor_row: expected %0d, got %0d", want.neighbor_row, got.neighbor_row);
            err_cnt++;
          end
          if (got.neighbor_col !== want.neighbor_col) begin
            $error("neighbor_col: expected %0d, got %0d", want.neighbor_col, got.neighbor_col);
            err_cnt++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            err_cnt++;
          end
        end
      end
      if (query_if.valid && query_if.ready) begin
        expand_query(query_if.payload.query_index);
        q_accepted++;
      end
    end
  end

  // watchdog on cycles without any transaction
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((query_if.valid && query_if.ready) || (result_if.valid && result_if.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** disc_neighbor_cell_enumerator_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    int n;
    int span_v;
    int lim_v;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults: map corners and middle
    push_query(0);
    push_query(1023);
    push_query(1047552);
    push_query(1048575);
    push_query(524800);
    settle();

    // tiny map, full span, every offset kept, centres in and out of the map
    apply_config(3, 5, 3 | (511 << 2), 31);
    push_query(0);
    push_query(7);
    push_query(14);
    push_query(20);
    push_query(1048575);
    settle();

    // zero rows, then zero columns
    apply_config(0, 7, 2, 8);
    push_query(3);
    settle();
    apply_config(5, 0, 2, 8);
    push_query(3);
    settle();

    // oversized map, centre only
    apply_config(2047, 2047, 0, 0);
    push_query(1048575);
    push_query(0);
    settle();

    // single cell map
    apply_config(1, 1, 2, 5);
    push_query(0);
    push_query(1);
    settle();

    // one column, tall map
    apply_config(1024, 1, 3, 18);
    push_query(1023);
    push_query(1048575);
    push_query(500);
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      span_v = $urandom_range(0, 3) | ($urandom_range(0, 511) << 2);
      lim_v  = ($urandom_range(0, 3) == 0) ? $urandom_range(19, 31) : $urandom_range(0, 18);
      lim_v  = lim_v | ($urandom_range(0, 63) << 5);
      apply_config(pick_dim(), pick_dim(), span_v, lim_v);
      n = $urandom_range(26, 36);
      for (int i = 0; i < n / 2; i++) query_backlog = {query_backlog, pick_query()};
      wait_drain();
      for (int i = n / 2; i < n; i++) query_backlog = {query_backlog, pick_query()};
      settle();
    end

    if (err_cnt == 0) begin
      $display("** disc_neighbor_cell_enumerator_unit: PASSED **");
    end else begin
      $display("** disc_neighbor_cell_enumerator_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/dnce_pkg.sv
rtl/core/dnce_if.sv
rtl/core/disc_neighbor_cell_enumerator_unit.sv
rtl/core/dnce_checker.sv
dv/disc_neighbor_cell_enumerator_unit_tb.sv
